FILE: hw/rtl/ssd_pkg.sv
// ssd_pkg: shared types, codes and constants for the servo command decoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ssd_pkg;

   // field widths
   localparam int RX_W        = 8;
   localparam int WORD_W      = 16;
   localparam int CMP_W       = 16;
   localparam int ANGLE_W     = 13;
   localparam int SPEED_W     = 14;
   localparam int ADDR_SLOT_W = 2;
   localparam int TEXT_SLOT_W = 4;
   localparam int STEER_LIM_W = 12;
   localparam int SPEED_LIM_W = 13;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int PULSE_W     = 8;
   localparam int QUOT_W      = 7;

   // text run length default
   localparam int TEXT_LEN_DEF = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEER_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_BASE  = 2'd2;

   // configuration reset values
   localparam logic [STEER_LIM_W-1:0] STEER_LIMIT_RST = 12'd1850;
   localparam logic [SPEED_LIM_W-1:0] SPEED_LIMIT_RST = 13'd5000;
   localparam logic [CMP_W-1:0]       PULSE_BASE_RST  = 16'd19000;
   localparam logic [CMP_W-1:0]       CMP_RST         = PULSE_BASE_RST - 16'd508;

   // hard clamp ceilings
   localparam logic [STEER_LIM_W-1:0] STEER_MAX = 12'd2700;
   localparam logic [SPEED_LIM_W-1:0] SPEED_MAX = 13'd5080;

   // command bytes accepted while idle
   localparam logic [RX_W-1:0] CMD_STEER_LO = 8'd5;
   localparam logic [RX_W-1:0] CMD_ADDR0    = 8'd6;
   localparam logic [RX_W-1:0] CMD_ADDR1    = 8'd7;
   localparam logic [RX_W-1:0] CMD_ADDR2    = 8'd8;
   localparam logic [RX_W-1:0] CMD_ADDR3    = 8'd9;
   localparam logic [RX_W-1:0] CMD_SPEED_LO = 8'd10;
   localparam logic [RX_W-1:0] CMD_SPEED_HI = 8'd11;
   localparam logic [RX_W-1:0] CMD_TEXT     = 8'd12;
   localparam logic [RX_W-1:0] CMD_STEER_HI = 8'd13;

   // pulse centre
   localparam logic [PULSE_W-1:0] PULSE_MID = 8'd127;

   // steering: floor(n / 2700) as (n * ceil(2^30 / 2700)) >> 30, exact for n <= 345599
   localparam int                     STEER_NUM_W = 19;
   localparam int                     STEER_SHIFT = 30;
   localparam logic [STEER_NUM_W-1:0] STEER_RECIP = 19'd397683;
   localparam logic [STEER_NUM_W-1:0] STEER_ROUND = 19'd2699;

   // speed: floor(n / 40) as (n * ceil(2^18 / 40)) >> 18, exact for n <= 5080
   localparam int                     SPEED_SHIFT = 18;
   localparam logic [SPEED_LIM_W-1:0] SPEED_RECIP = 13'd6554;

   typedef enum logic [3:0] {
      PS_IDLE     = 4'd0,
      PS_STEER_LO = 4'd1,
      PS_STEER_HI = 4'd2,
      PS_SPEED_LO = 4'd3,
      PS_SPEED_HI = 4'd4,
      PS_ADDR0    = 4'd5,
      PS_ADDR1    = 4'd6,
      PS_ADDR2    = 4'd7,
      PS_ADDR3    = 4'd8,
      PS_TEXT     = 4'd9
   } parse_state_type;

   // per-beat events carried down the pipe
   typedef struct packed {
      logic                          steer_update;
      logic                          speed_update;
      logic                          addr_write;
      logic [ADDR_SLOT_W-1:0]        addr_slot;
      logic                          text_write;
      logic [TEXT_SLOT_W-1:0]        text_slot;
      logic [RX_W-1:0]               data_out;
      logic signed [ANGLE_W-1:0]     steer_angle;
      logic signed [SPEED_W-1:0]     speed_value;
   } event_type;

   typedef struct packed {
      event_type                     ev;
      logic                          steer_neg;
      logic [STEER_NUM_W-1:0]        steer_num;
      logic                          speed_neg;
      logic [SPEED_LIM_W-1:0]        speed_mag;
   } scale_in_type;

   typedef struct packed {
      event_type                     ev;
      logic                          steer_neg;
      logic [QUOT_W-1:0]             steer_quot;
      logic                          speed_neg;
      logic [QUOT_W-1:0]             speed_quot;
   } scale_out_type;

endpackage

FILE: hw/rtl/spi_servo_command_decoder.sv
// spi_servo_command_decoder: top level, configuration registers and pipe wiring
// depends on ssd_pkg, ssd_parser, ssd_scaler and ssd_output
`timescale 1ns / 1ps

// usage
// - req channel: one received serial byte per beat (req_rx_byte), taken at a
//   rising edge with req_valid high and req_stall low
// - rsp channel: exactly one result beat per request beat, in order; carries
//   the held steering and speed compare values, update flags, the held clamped
//   words and the address or text write event for that byte
// - csr port: csr_write_en with csr_index and csr_write_data writes one of
//   steer_limit, speed_limit, pulse_base; indexes past the list are dropped;
//   write only while the pipe is empty
// - pipe: a byte taken is registered in the parser, then in the scaler, then in
//   the result register, from which it is shown on the rsp channel
// - throughput: one byte per cycle while rsp_stall stays low; each of the three
//   register stages (parser, reciprocal multiply, compare and result register)
//   takes a new beat in the cycle it hands one on
// - stall: a stalled result holds; the upstream stages keep filling any empty
//   slot, so up to two more bytes are taken before req_stall rises
// - reset: parser idle, words and text position cleared, both compare values
//   at pulse_base reset minus 508, limits and base back to their reset values,
//   no result pending
module spi_servo_command_decoder #(
   parameter int TEXT_LEN = ssd_pkg::TEXT_LEN_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request beats
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ssd_pkg::RX_W-1:0]              req_rx_byte,
   // result beats
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ssd_pkg::CMP_W-1:0]             rsp_steer_compare,
   output logic [ssd_pkg::CMP_W-1:0]             rsp_speed_compare,
   output logic                                  rsp_steer_update,
   output logic                                  rsp_speed_update,
   output logic signed [ssd_pkg::ANGLE_W-1:0]    rsp_steer_angle,
   output logic signed [ssd_pkg::SPEED_W-1:0]    rsp_speed_value,
   output logic                                  rsp_addr_write,
   output logic [ssd_pkg::ADDR_SLOT_W-1:0]       rsp_addr_slot,
   output logic                                  rsp_text_write,
   output logic [ssd_pkg::TEXT_SLOT_W-1:0]       rsp_text_slot,
   output logic [ssd_pkg::RX_W-1:0]              rsp_data_out,
   // configuration writes
   input  logic                                  csr_write_en,
   input  logic [ssd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ssd_pkg::CSR_DATA_W-1:0]        csr_write_data
);
   import ssd_pkg::*;

   logic [STEER_LIM_W-1:0]  steer_limit_ff;
   logic [SPEED_LIM_W-1:0]  speed_limit_ff;
   logic [CMP_W-1:0]        pulse_base_ff;

   logic                    parse_ready, scale_ready, out_ready;
   logic                    parse_valid, scale_valid;
   scale_in_type            parse_data;
   scale_out_type           scale_data;
   logic                    req_fire;

   // configuration registers, each truncated to its own width
   always_ff @(posedge clock) begin
      if (reset) begin
         steer_limit_ff <= STEER_LIMIT_RST;
         speed_limit_ff <= SPEED_LIMIT_RST;
         pulse_base_ff  <= PULSE_BASE_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_STEER_LIMIT: steer_limit_ff <= csr_write_data[STEER_LIM_W-1:0];
            CSR_SPEED_LIMIT: speed_limit_ff <= csr_write_data[SPEED_LIM_W-1:0];
            CSR_PULSE_BASE:  pulse_base_ff  <= csr_write_data[CMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // a beat enters whenever the parser stage has room
   assign req_stall = !parse_ready;
   assign req_fire  = req_valid && parse_ready;

   ssd_parser #(
      .TEXT_LEN    (TEXT_LEN)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .beat_fire   (req_fire),
      .rx_byte     (req_rx_byte),
      .steer_limit (steer_limit_ff),
      .speed_limit (speed_limit_ff),
      .dn_ready    (scale_ready),
      .up_ready    (parse_ready),
      .stage_valid (parse_valid),
      .stage_data  (parse_data)
   );

   ssd_scaler u_scaler (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (parse_valid),
      .up_data     (parse_data),
      .dn_ready    (out_ready),
      .up_ready    (scale_ready),
      .stage_valid (scale_valid),
      .stage_data  (scale_data)
   );

   ssd_output u_output (
      .clock             (clock),
      .reset             (reset),
      .up_valid          (scale_valid),
      .up_data           (scale_data),
      .pulse_base        (pulse_base_ff),
      .up_ready          (out_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_steer_compare (rsp_steer_compare),
      .rsp_speed_compare (rsp_speed_compare),
      .rsp_steer_update  (rsp_steer_update),
      .rsp_speed_update  (rsp_speed_update),
      .rsp_steer_angle   (rsp_steer_angle),
      .rsp_speed_value   (rsp_speed_value),
      .rsp_addr_write    (rsp_addr_write),
      .rsp_addr_slot     (rsp_addr_slot),
      .rsp_text_write    (rsp_text_write),
      .rsp_text_slot     (rsp_text_slot),
      .rsp_data_out      (rsp_data_out)
   );

endmodule

FILE: hw/rtl/ssd_parser.sv
// ssd_parser: byte parser state machine, word assembly and clamping
// first pipe stage; depends on ssd_pkg
`timescale 1ns / 1ps

module ssd_parser #(
   parameter int TEXT_LEN = ssd_pkg::TEXT_LEN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              beat_fire,
   input  logic [ssd_pkg::RX_W-1:0]          rx_byte,
   input  logic [ssd_pkg::STEER_LIM_W-1:0]   steer_limit,
   input  logic [ssd_pkg::SPEED_LIM_W-1:0]   speed_limit,
   input  logic                              dn_ready,
   output logic                              up_ready,
   output logic                              stage_valid,
   output ssd_pkg::scale_in_type             stage_data
);
   import ssd_pkg::*;

   localparam logic [TEXT_SLOT_W:0] TEXT_LEN_V = (TEXT_SLOT_W+1)'(TEXT_LEN);

   parse_state_type           state_ff, state_in;
   logic [WORD_W-1:0]         steer_word_ff, steer_word_in;
   logic [WORD_W-1:0]         speed_word_ff, speed_word_in;
   logic [TEXT_SLOT_W-1:0]    text_pos_ff, text_pos_in;
   logic                      stage_valid_ff;
   scale_in_type              stage_data_ff, stage_data_in;

   logic [STEER_LIM_W-1:0]    steer_lim;
   logic [SPEED_LIM_W-1:0]    speed_lim;
   logic signed [WORD_W-1:0]  steer_raw, steer_lim_s, steer_clamp, steer_abs;
   logic signed [WORD_W-1:0]  speed_raw, speed_lim_s, speed_clamp, speed_abs;
   logic [STEER_NUM_W-1:0]    steer_prod127;
   logic [TEXT_SLOT_W:0]      text_pos_inc;
   logic                      text_last;

   // clamp path for a completed word
   always_comb begin
      steer_lim   = (steer_limit > STEER_MAX) ? STEER_MAX : steer_limit;
      speed_lim   = (speed_limit > SPEED_MAX) ? SPEED_MAX : speed_limit;
      steer_lim_s = signed'({{(WORD_W-STEER_LIM_W){1'b0}}, steer_lim});
      speed_lim_s = signed'({{(WORD_W-SPEED_LIM_W){1'b0}}, speed_lim});
      steer_raw   = signed'({rx_byte | steer_word_ff[WORD_W-1:RX_W], steer_word_ff[RX_W-1:0]});
      speed_raw   = signed'({rx_byte | speed_word_ff[WORD_W-1:RX_W], speed_word_ff[RX_W-1:0]});
      if (steer_raw > steer_lim_s) begin
         steer_clamp = steer_lim_s;
      end else if (steer_raw < -steer_lim_s) begin
         steer_clamp = -steer_lim_s;
      end else begin
         steer_clamp = steer_raw;
      end
      if (speed_raw > speed_lim_s) begin
         speed_clamp = speed_lim_s;
      end else if (speed_raw < -speed_lim_s) begin
         speed_clamp = -speed_lim_s;
      end else begin
         speed_clamp = speed_raw;
      end
      steer_abs     = steer_clamp[WORD_W-1] ? -steer_clamp : steer_clamp;
      speed_abs     = speed_clamp[WORD_W-1] ? -speed_clamp : speed_clamp;
      // magnitude times 127 as a shift and subtract
      steer_prod127 = {steer_abs[STEER_LIM_W-1:0], 7'b0}
                    - {7'b0, steer_abs[STEER_LIM_W-1:0]};
      text_pos_inc  = {1'b0, text_pos_ff} + 1'b1;
      text_last     = (text_pos_inc >= TEXT_LEN_V);
   end

   // next state
   always_comb begin
      state_in = PS_IDLE;
      unique case (state_ff)
         PS_TEXT: begin
            state_in = text_last ? PS_IDLE : PS_TEXT;
         end
         PS_STEER_LO, PS_STEER_HI, PS_SPEED_LO, PS_SPEED_HI,
         PS_ADDR0, PS_ADDR1, PS_ADDR2, PS_ADDR3: begin
            state_in = PS_IDLE;
         end
         default: begin
            priority if (rx_byte == CMD_STEER_LO) state_in = PS_STEER_LO;
            else if (rx_byte == CMD_STEER_HI)     state_in = PS_STEER_HI;
            else if (rx_byte == CMD_SPEED_LO)     state_in = PS_SPEED_LO;
            else if (rx_byte == CMD_SPEED_HI)     state_in = PS_SPEED_HI;
            else if (rx_byte == CMD_ADDR0)        state_in = PS_ADDR0;
            else if (rx_byte == CMD_ADDR1)        state_in = PS_ADDR1;
            else if (rx_byte == CMD_ADDR2)        state_in = PS_ADDR2;
            else if (rx_byte == CMD_ADDR3)        state_in = PS_ADDR3;
            else if (rx_byte == CMD_TEXT)         state_in = PS_TEXT;
            else                                  state_in = PS_IDLE;
         end
      endcase
   end

   // outputs of the parser per beat
   always_comb begin
      steer_word_in = steer_word_ff;
      speed_word_in = speed_word_ff;
      text_pos_in   = text_pos_ff;
      stage_data_in = '0;
      stage_data_in.ev.steer_angle = steer_clamp[ANGLE_W-1:0];
      stage_data_in.ev.speed_value = speed_clamp[SPEED_W-1:0];
      stage_data_in.steer_neg = steer_clamp[WORD_W-1];
      stage_data_in.steer_num = steer_clamp[WORD_W-1] ? steer_prod127 + STEER_ROUND
                                                      : steer_prod127;
      stage_data_in.speed_neg = speed_clamp[WORD_W-1];
      stage_data_in.speed_mag = speed_abs[SPEED_LIM_W-1:0];
      unique case (state_ff)
         PS_STEER_LO: begin
            steer_word_in = {{(WORD_W-RX_W){1'b0}}, rx_byte};
         end
         PS_STEER_HI: begin
            steer_word_in = steer_clamp;
            stage_data_in.ev.steer_update = 1'b1;
         end
         PS_SPEED_LO: begin
            speed_word_in = {{(WORD_W-RX_W){1'b0}}, rx_byte};
         end
         PS_SPEED_HI: begin
            speed_word_in = speed_clamp;
            stage_data_in.ev.speed_update = 1'b1;
         end
         PS_ADDR0: begin
            stage_data_in.ev.addr_write = 1'b1;
            stage_data_in.ev.addr_slot  = 2'd0;
            stage_data_in.ev.data_out   = rx_byte;
         end
         PS_ADDR1: begin
            stage_data_in.ev.addr_write = 1'b1;
            stage_data_in.ev.addr_slot  = 2'd1;
            stage_data_in.ev.data_out   = rx_byte;
         end
         PS_ADDR2: begin
            stage_data_in.ev.addr_write = 1'b1;
            stage_data_in.ev.addr_slot  = 2'd2;
            stage_data_in.ev.data_out   = rx_byte;
         end
         PS_ADDR3: begin
            stage_data_in.ev.addr_write = 1'b1;
            stage_data_in.ev.addr_slot  = 2'd3;
            stage_data_in.ev.data_out   = rx_byte;
         end
         PS_TEXT: begin
            stage_data_in.ev.text_write = 1'b1;
            stage_data_in.ev.text_slot  = text_pos_ff;
            stage_data_in.ev.data_out   = rx_byte;
            text_pos_in = text_last ? '0 : text_pos_inc[TEXT_SLOT_W-1:0];
         end
         default: begin
         end
      endcase
   end

   assign up_ready = !stage_valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= PS_IDLE;
         steer_word_ff  <= '0;
         speed_word_ff  <= '0;
         text_pos_ff    <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         if (beat_fire) begin
            state_ff      <= state_in;
            steer_word_ff <= steer_word_in;
            speed_word_ff <= speed_word_in;
            text_pos_ff   <= text_pos_in;
         end
         if (up_ready) begin
            stage_valid_ff <= beat_fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (beat_fire) begin
         stage_data_ff <= stage_data_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage_data  = stage_data_ff;

endmodule

FILE: hw/rtl/ssd_scaler.sv
// ssd_scaler: reciprocal multiply stage for the steering and speed quotients
// second pipe stage; depends on ssd_pkg
`timescale 1ns / 1ps

module ssd_scaler (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   input  ssd_pkg::scale_in_type   up_data,
   input  logic                    dn_ready,
   output logic                    up_ready,
   output logic                    stage_valid,
   output ssd_pkg::scale_out_type  stage_data
);
   import ssd_pkg::*;

   logic [2*STEER_NUM_W-1:0]  steer_prod;
   logic [2*SPEED_LIM_W-1:0]  speed_prod;
   scale_out_type             stage_data_ff, stage_data_in;
   logic                      stage_valid_ff;

   always_comb begin
      steer_prod = up_data.steer_num * STEER_RECIP;
      speed_prod = up_data.speed_mag * SPEED_RECIP;
      stage_data_in.ev         = up_data.ev;
      stage_data_in.steer_neg  = up_data.steer_neg;
      stage_data_in.steer_quot = steer_prod[STEER_SHIFT +: QUOT_W];
      stage_data_in.speed_neg  = up_data.speed_neg;
      stage_data_in.speed_quot = speed_prod[SPEED_SHIFT +: QUOT_W];
   end

   assign up_ready = !stage_valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (up_ready) begin
         stage_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         stage_data_ff <= stage_data_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage_data  = stage_data_ff;

endmodule

FILE: hw/rtl/ssd_output.sv
// ssd_output: pulse value, compare calculation and the result register
// last pipe stage, also holds the compare and clamped values; depends on ssd_pkg
`timescale 1ns / 1ps

module ssd_output (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  up_valid,
   input  ssd_pkg::scale_out_type                up_data,
   input  logic [ssd_pkg::CMP_W-1:0]             pulse_base,
   output logic                                  up_ready,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ssd_pkg::CMP_W-1:0]             rsp_steer_compare,
   output logic [ssd_pkg::CMP_W-1:0]             rsp_speed_compare,
   output logic                                  rsp_steer_update,
   output logic                                  rsp_speed_update,
   output logic signed [ssd_pkg::ANGLE_W-1:0]    rsp_steer_angle,
   output logic signed [ssd_pkg::SPEED_W-1:0]    rsp_speed_value,
   output logic                                  rsp_addr_write,
   output logic [ssd_pkg::ADDR_SLOT_W-1:0]       rsp_addr_slot,
   output logic                                  rsp_text_write,
   output logic [ssd_pkg::TEXT_SLOT_W-1:0]       rsp_text_slot,
   output logic [ssd_pkg::RX_W-1:0]              rsp_data_out
);
   import ssd_pkg::*;

   logic [PULSE_W-1:0]         steer_pulse, speed_pulse;
   logic [CMP_W-1:0]           steer_cmp_new, speed_cmp_new;
   logic                       load;

   logic                       rsp_valid_ff;
   logic [CMP_W-1:0]           steer_cmp_ff, speed_cmp_ff;
   logic signed [ANGLE_W-1:0]  steer_angle_ff;
   logic signed [SPEED_W-1:0]  speed_value_ff;
   event_type                  ev_ff;

   always_comb begin
      steer_pulse = up_data.steer_neg ? PULSE_MID - {1'b0, up_data.steer_quot}
                                      : PULSE_MID + {1'b0, up_data.steer_quot};
      speed_pulse = up_data.speed_neg ? PULSE_MID - {1'b0, up_data.speed_quot}
                                      : PULSE_MID + {1'b0, up_data.speed_quot};
      // wraps modulo 2^16 for a small base
      steer_cmp_new = pulse_base - {{(CMP_W-PULSE_W-2){1'b0}}, steer_pulse, 2'b00};
      speed_cmp_new = pulse_base - {{(CMP_W-PULSE_W-2){1'b0}}, speed_pulse, 2'b00};
   end

   assign up_ready = !rsp_valid_ff || !rsp_stall;
   assign load     = up_ready && up_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         steer_cmp_ff   <= CMP_RST;
         speed_cmp_ff   <= CMP_RST;
         steer_angle_ff <= '0;
         speed_value_ff <= '0;
      end else begin
         if (up_ready) begin
            rsp_valid_ff <= up_valid;
         end
         if (load && up_data.ev.steer_update) begin
            steer_cmp_ff   <= steer_cmp_new;
            steer_angle_ff <= up_data.ev.steer_angle;
         end
         if (load && up_data.ev.speed_update) begin
            speed_cmp_ff   <= speed_cmp_new;
            speed_value_ff <= up_data.ev.speed_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ev_ff <= up_data.ev;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_steer_compare = steer_cmp_ff;
   assign rsp_speed_compare = speed_cmp_ff;
   assign rsp_steer_update  = ev_ff.steer_update;
   assign rsp_speed_update  = ev_ff.speed_update;
   assign rsp_steer_angle   = steer_angle_ff;
   assign rsp_speed_value   = speed_value_ff;
   assign rsp_addr_write    = ev_ff.addr_write;
   assign rsp_addr_slot     = ev_ff.addr_slot;
   assign rsp_text_write    = ev_ff.text_write;
   assign rsp_text_slot     = ev_ff.text_slot;
   assign rsp_data_out      = ev_ff.data_out;

endmodule
